// File: hw/rtl/triangle_perimeter_area_core_defines.svh
// Assertion macros used by the checker file of the triangle core.
`ifndef TRIANGLE_PERIMETER_AREA_CORE_DEFINES_SVH
`define TRIANGLE_PERIMETER_AREA_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TPA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tpa_pkg.sv
`default_nettype none

package tpa_pkg;

    localparam int COORD_BITS  = 16;
    localparam int MAG_BITS    = COORD_BITS;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * MAG_BITS;
    localparam int RAD_BITS    = PROD_BITS + 1;
    localparam int ROOT_BITS   = (RAD_BITS + 1) / 2;
    localparam int PERIM_BITS  = 19;
    localparam int AREA_BITS   = 32;
    localparam int SERIAL_BITS = 32;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic signed [COORD_BITS-1:0] third_x;
        logic signed [COORD_BITS-1:0] third_y;
    } in_word_t;

    typedef struct packed {
        logic [PERIM_BITS-1:0]  perimeter;
        logic [AREA_BITS-1:0]   area;
        logic [SERIAL_BITS-1:0] serial_number;
    } out_word_t;

endpackage

`default_nettype wire

// File: hw/rtl/tpa_isqrt.sv
`default_nettype none

module tpa_isqrt
    import tpa_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [RAD_BITS-1:0]  radicand,
    output logic                      done,
    output logic [ROOT_BITS-1:0]      root
);

    localparam int PAD_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 1;
    localparam int SH_BITS    = REM_BITS + 2;
    localparam int COUNT_BITS = $clog2(ROOT_BITS);

    logic [PAD_BITS-1:0]   rad_reg;
    logic [REM_BITS-1:0]   rem_reg;
    logic [ROOT_BITS-1:0]  root_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [SH_BITS-1:0] rem_sh;
    logic [SH_BITS-1:0] trial;
    logic [SH_BITS-1:0] rem_fit;
    logic               fits;

    // One result bit per cycle: bring down two radicand bits and try 4*root+1.
    always_comb begin
        rem_sh  = {rem_reg, rad_reg[PAD_BITS-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        fits    = (rem_sh >= trial);
        rem_fit = rem_sh - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= COUNT_BITS'(ROOT_BITS - 1);
            end else if (busy_reg) begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= PAD_BITS'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[PAD_BITS-3:0], 2'b00};
            rem_reg  <= fits ? rem_fit[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
            root_reg <= {root_reg[ROOT_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: hw/rtl/triangle_perimeter_area_core.sv
// Triangle core: each word carries three vertices in signed Q11.4 and yields one
// result word with the perimeter (sum of the three floored side lengths, Q.4), the
// area (half the absolute cross product, floored, Q.8) and a serial number that
// counts triangles from 1 and wraps. A new word is taken only once the result of the
// previous triangle has been loaded into the output register. The time per triangle is set by
// the square-root unit, which produces one root bit per cycle and runs 17 steps for
// each of the three sides, and by the single 16 by 16 multiplier that forms the
// squares and the two cross terms one at a time. The result sits in an output
// register, so the next triangle may be accepted while a result waits to be taken.
`default_nettype none

module triangle_perimeter_area_core
    import tpa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIFF  = 4'd1;
    localparam logic [3:0] ST_MULA  = 4'd2;
    localparam logic [3:0] ST_MULB  = 4'd3;
    localparam logic [3:0] ST_START = 4'd4;
    localparam logic [3:0] ST_ROOT  = 4'd5;
    localparam logic [3:0] ST_MULC  = 4'd6;
    localparam logic [3:0] ST_AREA  = 4'd7;

    localparam logic [2:0] PH_SIDE0  = 3'd0;
    localparam logic [2:0] PH_SIDE1  = 3'd1;
    localparam logic [2:0] PH_SIDE2  = 3'd2;
    localparam logic [2:0] PH_AREA_U = 3'd3;
    localparam logic [2:0] PH_AREA_V = 3'd4;

    logic [3:0]             state_reg, state_next;
    logic [2:0]             phase_reg;
    in_word_t               coord_reg;
    logic [MAG_BITS-1:0]    op_a_reg;
    logic [MAG_BITS-1:0]    op_b_reg;
    logic                   neg_reg;
    logic [PROD_BITS-1:0]   prod_a_reg;
    logic [PROD_BITS-1:0]   prod_b_reg;
    logic                   n1_reg;
    logic                   n2_reg;
    logic [PERIM_BITS-1:0]  perim_reg;
    logic [SERIAL_BITS-1:0] count_reg;
    logic                   out_valid_reg;
    out_word_t              out_data_reg;

    logic signed [COORD_BITS-1:0] ax, bx, ay, by;
    logic signed [DIFF_BITS-1:0]  dx, dy;
    logic [DIFF_BITS-1:0]         dx_abs, dy_abs;
    logic [MAG_BITS-1:0]          mul_l, mul_r;
    logic [PROD_BITS-1:0]         product;
    logic [PROD_BITS:0]           cross_sum;
    logic [PROD_BITS-1:0]         cross_diff;
    logic [AREA_BITS-1:0]         half;
    logic                         sqrt_start;
    logic                         sqrt_done;
    logic [ROOT_BITS-1:0]         root;
    logic                         out_load;

    tpa_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand ({1'b0, prod_a_reg} + {1'b0, prod_b_reg}),
        .done     (sqrt_done),
        .root     (root)
    );

    always_comb begin
        ax = coord_reg.first_x;
        bx = coord_reg.second_x;
        ay = coord_reg.first_y;
        by = coord_reg.second_y;
        unique case (phase_reg)
            PH_SIDE0: begin
            end
            PH_SIDE1: begin
                ax = coord_reg.second_x;
                bx = coord_reg.third_x;
                ay = coord_reg.second_y;
                by = coord_reg.third_y;
            end
            PH_SIDE2: begin
                ax = coord_reg.third_x;
                bx = coord_reg.first_x;
                ay = coord_reg.third_y;
                by = coord_reg.first_y;
            end
            PH_AREA_U: begin
                by = coord_reg.third_y;
            end
            PH_AREA_V: begin
                bx = coord_reg.third_x;
            end
            default: begin
            end
        endcase
        dx     = DIFF_BITS'(bx) - DIFF_BITS'(ax);
        dy     = DIFF_BITS'(by) - DIFF_BITS'(ay);
        dx_abs = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
        dy_abs = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
    end

    always_comb begin
        mul_l = op_a_reg;
        mul_r = op_b_reg;
        unique case (state_reg)
            ST_MULA: mul_r = op_a_reg;
            ST_MULB: mul_l = op_b_reg;
            default: begin
            end
        endcase
        product = mul_l * mul_r;
    end

    always_comb begin
        cross_sum  = {1'b0, prod_a_reg} + {1'b0, prod_b_reg};
        cross_diff = (prod_a_reg >= prod_b_reg) ? (prod_a_reg - prod_b_reg)
                                                : (prod_b_reg - prod_a_reg);
        half = (n1_reg != n2_reg) ? cross_sum[PROD_BITS -: AREA_BITS]
                                  : AREA_BITS'(cross_diff >> 1);
    end

    assign sqrt_start = (state_reg == ST_START);
    assign out_load   = (state_reg == ST_AREA) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_DIFF;
            ST_DIFF:  state_next = (phase_reg >= PH_AREA_U) ? ST_MULC : ST_MULA;
            ST_MULA:  state_next = ST_MULB;
            ST_MULB:  state_next = ST_START;
            ST_START: state_next = ST_ROOT;
            ST_ROOT:  if (sqrt_done) state_next = ST_DIFF;
            ST_MULC:  state_next = (phase_reg == PH_AREA_V) ? ST_AREA : ST_DIFF;
            ST_AREA:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_SIDE0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE) begin
                phase_reg <= PH_SIDE0;
            end else if ((state_reg == ST_ROOT && sqrt_done) || state_reg == ST_MULC) begin
                phase_reg <= phase_reg + 1'b1;
            end
            if (out_load) begin
                count_reg     <= count_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            coord_reg <= s_data;
            perim_reg <= '0;
        end
        if (state_reg == ST_DIFF) begin
            op_a_reg <= dx_abs[MAG_BITS-1:0];
            op_b_reg <= dy_abs[MAG_BITS-1:0];
            neg_reg  <= dx[DIFF_BITS-1] ^ dy[DIFF_BITS-1];
        end
        if (state_reg == ST_MULA) begin
            prod_a_reg <= product;
        end
        if (state_reg == ST_MULB) begin
            prod_b_reg <= product;
        end
        if (state_reg == ST_ROOT && sqrt_done) begin
            perim_reg <= perim_reg + PERIM_BITS'(root);
        end
        if (state_reg == ST_MULC) begin
            if (phase_reg == PH_AREA_U) begin
                prod_a_reg <= product;
                n1_reg     <= neg_reg && (product != '0);
            end else begin
                prod_b_reg <= product;
                n2_reg     <= neg_reg && (product != '0);
            end
        end
        if (out_load) begin
            out_data_reg.perimeter     <= perim_reg;
            out_data_reg.area          <= half;
            out_data_reg.serial_number <= count_reg + 1'b1;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tpa_checker.sv
`default_nettype none

`include "triangle_perimeter_area_core_defines.svh"

module tpa_checker
    import tpa_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_word_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_word_t m_data
);

    // A stalled result word keeps its contents.
    `TPA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")

    // The core works on one triangle at a time.
    `TPA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken again right after a word was accepted")

    // A new result appears exactly when the core returns to waiting for input.
    `TPA_ASSERT_NOW(a_result_frees_input, aclk, aresetn, $rose(m_valid), $rose(s_ready), "result appeared without the core going idle")

    // Three sides of at most 92681 each bound the perimeter.
    `TPA_ASSERT_NOW(a_perimeter_bound, aclk, aresetn, m_valid, m_data.perimeter <= 19'd278043, "perimeter beyond the largest possible triangle")

endmodule

bind triangle_perimeter_area_core tpa_checker u_tpa_checker (.*);

`default_nettype wire
